[src/scrr_pkg.sv]
// Package for the serial command report retransmitter.
// Holds widths, character codes and the structs shared between the block files.
// No dependencies.
package scrr_pkg;

	localparam int BUFFER_DEPTH = 32;
	localparam int IDX_W = 6;
	localparam int HEAD_LEN = 4;
	localparam int BYTE_W = 8;
	localparam int SAMPLE_W = 12;
	localparam int PERIOD_W = 16;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd300;

	localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
	localparam logic [BYTE_W-1:0] CH_START = 8'h21;
	localparam logic [BYTE_W-1:0] CH_END   = 8'h23;
	localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
	localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
	localparam logic [BYTE_W-1:0] CH_T     = 8'h54;
	localparam logic [BYTE_W-1:0] CH_O     = 8'h4F;
	localparam logic [BYTE_W-1:0] CH_K     = 8'h4B;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic rst;
		logic ok;
	} cmd_evt_t;

	typedef struct packed {
		logic                valid;
		logic [SAMPLE_W-1:0] value;
		logic                fresh;
	} report_t;

endpackage

[src/scrr_req_if.sv]
// Input channel of the retransmitter: received bytes and timer ticks.
// Depends on scrr_pkg for field widths.
interface scrr_req_if;
	import scrr_pkg::*;

	logic                valid;
	logic                ready;
	logic                op;
	logic [BYTE_W-1:0]   rx_byte;
	logic [SAMPLE_W-1:0] adc_sample;

	modport source (output valid, op, rx_byte, adc_sample, input ready);
	modport sink (input valid, op, rx_byte, adc_sample, output ready);
endinterface

[src/scrr_rsp_if.sv]
// Output channel of the retransmitter: report frames.
// Depends on scrr_pkg for field widths.
interface scrr_rsp_if;
	import scrr_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] report_value;
	logic                report_fresh;

	modport source (output valid, report_value, report_fresh, input ready);
	modport sink (input valid, report_value, report_fresh, output ready);
endinterface

[src/serial_command_report_retransmitter.sv]
// Top level of the serial command report retransmitter: input register, parser,
// resend scheduler and report output register. Depends on scrr_pkg and the
// scrr_req_if / scrr_rsp_if interfaces.

// Each beat on req is a received byte (op 0) or a timer tick (op 1). Bytes
// build a command; "!RST#" latches adc_sample, sends it at once with
// report_fresh set and starts periodic resending, "!OK#" stops it. While
// resending, a report with report_fresh clear goes out every resend_period+1
// ticks. The block takes one beat per cycle: a beat is held in the
// input register, is decoded and applied to the state as it leaves it, and its
// report, if any, appears on rsp the cycle after. Throughput drops only when
// the report register is full and rsp is not ready. resend_period is written
// through cfg_we/cfg_wdata and takes effect at the next reload of the count.
module serial_command_report_retransmitter (
	input  logic                          clk,
	input  logic                          arst_n,
	scrr_req_if.sink                      req,
	scrr_rsp_if.source                    rsp,
	input  logic                          cfg_we,
	input  logic [scrr_pkg::PERIOD_W-1:0] cfg_wdata
);
	import scrr_pkg::*;

	logic                s1_valid_q;
	logic                op_s1;
	logic [BYTE_W-1:0]   rx_byte_s1;
	logic [SAMPLE_W-1:0] adc_sample_s1;
	logic [PERIOD_W-1:0] period_q;
	logic                rsp_valid_q;
	logic [SAMPLE_W-1:0] value_q;
	logic                fresh_q;
	logic                adv;
	logic                step;
	cmd_evt_t            evt;
	report_t             res;

	assign adv       = !rsp_valid_q || rsp.ready;
	assign step      = s1_valid_q && adv;
	assign req.ready = !s1_valid_q || adv;

	assign rsp.valid        = rsp_valid_q;
	assign rsp.report_value = value_q;
	assign rsp.report_fresh = fresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			period_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1         <= req.op;
			rx_byte_s1    <= req.rx_byte;
			adc_sample_s1 <= req.adc_sample;
		end
	end

	scrr_cmd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step && op_s1 == OP_BYTE),
		.rx_byte (rx_byte_s1),
		.evt     (evt)
	);

	scrr_resend_sched u_sched (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (step && op_s1 == OP_TICK),
		.evt        (evt),
		.adc_sample (adc_sample_s1),
		.period     (period_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			value_q <= res.value;
			fresh_q <= res.fresh;
		end
	end

endmodule

[src/scrr_cmd_parser.sv]
// Command buffer and parser: tracks the write index and the first four buffer
// positions, and flags RST# and OK# commands. Depends on scrr_pkg.
module scrr_cmd_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [scrr_pkg::BYTE_W-1:0]   rx_byte,
	output scrr_pkg::cmd_evt_t            evt
);
	import scrr_pkg::*;

	logic [BYTE_W-1:0] head_q [HEAD_LEN];
	logic [BYTE_W-1:0] head_nx [HEAD_LEN];
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  idx_nx;
	logic [IDX_W:0]    idx_inc;
	logic              in_cmd_q;
	logic              is_bs;
	logic              is_start;
	logic              is_end;

	assign is_bs    = (rx_byte == CH_BS);
	assign is_start = (rx_byte == CH_START);
	assign is_end   = (rx_byte == CH_END);
	assign idx_inc  = {1'b0, idx_q} + (IDX_W+1)'(1);

	// The head is checked as it stands after this byte has been stored.
	always_comb begin
		for (int i = 0; i < HEAD_LEN; i++) begin
			head_nx[i] = (!is_bs && idx_q == IDX_W'(i)) ? rx_byte : head_q[i];
		end
		if (is_start) begin
			idx_nx = '0;
		end else if (is_bs) begin
			idx_nx = (idx_q != '0) ? idx_q - IDX_W'(1) : idx_q;
		end else if (idx_inc >= (IDX_W+1)'(BUFFER_DEPTH)) begin
			idx_nx = '0;
		end else begin
			idx_nx = idx_inc[IDX_W-1:0];
		end
	end

	always_comb begin
		evt.rst = step && in_cmd_q && is_end && head_nx[0] == CH_R && head_nx[1] == CH_S
			&& head_nx[2] == CH_T && head_nx[3] == CH_END;
		evt.ok  = step && in_cmd_q && is_end && !evt.rst && head_nx[0] == CH_O
			&& head_nx[1] == CH_K && head_nx[2] == CH_END;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			in_cmd_q <= 1'b0;
			for (int i = 0; i < HEAD_LEN; i++) begin
				head_q[i] <= '0;
			end
		end else if (step) begin
			idx_q <= idx_nx;
			for (int i = 0; i < HEAD_LEN; i++) begin
				head_q[i] <= head_nx[i];
			end
			if (is_start) begin
				in_cmd_q <= 1'b1;
			end else if (is_end) begin
				in_cmd_q <= 1'b0;
			end
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, idx_q} < (IDX_W+1)'(BUFFER_DEPTH))
		else $error("write index left the buffer");

	a_start_enters: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_start |=> in_cmd_q && idx_q == '0)
		else $error("start mark did not open a command");

endmodule

[src/scrr_resend_sched.sv]
// Resend scheduler: holds the latched sample, the resend flag and the tick
// countdown, and forms the report for each item. Depends on scrr_pkg.
module scrr_resend_sched (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            tick,
	input  scrr_pkg::cmd_evt_t              evt,
	input  logic [scrr_pkg::SAMPLE_W-1:0]   adc_sample,
	input  logic [scrr_pkg::PERIOD_W-1:0]   period,
	output scrr_pkg::report_t               res
);
	import scrr_pkg::*;

	logic                resending_q;
	logic [PERIOD_W-1:0] countdown_q;
	logic [SAMPLE_W-1:0] held_q;
	logic                due;

	assign due = tick && resending_q && countdown_q == '0;

	always_comb begin
		res.valid = evt.rst || due;
		res.value = evt.rst ? adc_sample : held_q;
		res.fresh = evt.rst;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resending_q <= 1'b0;
			countdown_q <= PERIOD_RESET;
			held_q      <= '0;
		end else if (evt.rst) begin
			held_q      <= adc_sample;
			resending_q <= 1'b1;
			countdown_q <= period;
		end else if (evt.ok && resending_q) begin
			resending_q <= 1'b0;
			countdown_q <= period;
		end else if (tick && resending_q) begin
			countdown_q <= due ? period : countdown_q - PERIOD_W'(1);
		end
	end

	a_rst_arms: assert property (@(posedge clk) disable iff (!arst_n)
		evt.rst |=> resending_q && held_q == $past(adc_sample))
		else $error("RST did not arm resending");

	a_ok_stops: assert property (@(posedge clk) disable iff (!arst_n)
		evt.ok && !evt.rst |=> !resending_q)
		else $error("OK did not stop resending");

	a_resend_only_armed: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !evt.rst |-> resending_q && !res.fresh)
		else $error("timed resend while idle");

endmodule
